// ----- rtl/chm_pkg.sv -----
// package: shared constants and types for the chained hash map engine
`timescale 1ns / 1ps
package chm_pkg;
  localparam int NUM_BUCKETS = 64;
  localparam int NUM_ENTRIES = 256;
  localparam int BKT_W = $clog2(NUM_BUCKETS);
  localparam int IDX_W = $clog2(NUM_ENTRIES);
  localparam int LNK_W = IDX_W + 1;
  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int CNT_W = 9;
  localparam int BC_W = 7;
  localparam logic [LNK_W-1:0] NIL_LINK = LNK_W'(NUM_ENTRIES);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_INVALID   = 3'd2,
    ST_FULL      = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // request from the controller to the modulo unit
  typedef struct packed {
    logic            start;
    logic [KEY_W-1:0] key;
    logic [BC_W-1:0]  bc;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] bucket;
  } mod_rsp_t;
endpackage

// ----- rtl/chm_mod.sv -----
// module: iterative key modulo bucket count, one quotient bit per cycle
`timescale 1ns / 1ps
module chm_mod (
  input  logic            clk,
  input  logic            rst_n,
  input  chm_pkg::mod_req_t req,
  output chm_pkg::mod_rsp_t rsp
);
  import chm_pkg::*;

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [BC_W:0]    rem_r, rem_nxt;
  logic [BC_W-1:0]  div_r, div_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [BC_W:0]    shifted;
  logic [BC_W-1:0]  bc_eff;

  always_comb begin
    bc_eff = req.bc;
    if (req.bc == '0) bc_eff = BC_W'(1);
    if (req.bc > BC_W'(NUM_BUCKETS)) bc_eff = BC_W'(NUM_BUCKETS);
  end

  always_comb begin
    key_nxt  = key_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[BC_W-1:0], key_r[KEY_W-1]};
    if (req.start) begin
      key_nxt  = req.key;
      rem_nxt  = '0;
      div_nxt  = bc_eff;
      cnt_nxt  = 5'(KEY_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // restoring step: remainder stays below the divisor
      if (shifted >= {1'b0, div_r}) rem_nxt = shifted - {1'b0, div_r};
      else rem_nxt = shifted;
      key_nxt = {key_r[KEY_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    key_r <= key_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.bucket = rem_r[BKT_W-1:0];
endmodule

// ----- rtl/chained_hash_map_engine.sv -----
// Chained hash map engine: keyed map with separate chaining over a 256-entry
// pool. One request at a time: the key modulo (bit-serial divider), then
// S_HEAD and S_HEADW to fetch the bucket head, then S_ENT and S_CHECK for each
// entry compared (at least once, even for an empty chain), then S_ACT, S_LINK
// and S_OUT to settle the status, write back the bucket head, links and free
// stack, and raise the result. The next request can be taken in the cycle
// after the result transaction. After reset a clearing pass over all 64
// buckets empties the bucket head memory before the first request is taken.
`timescale 1ns / 1ps
module chained_hash_map_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // cmd[1:0], key[32:2], value[64:33]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[2:0], found_value[34:3], entry_count[43:35]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data    // bucket_count[6:0]
);
  import chm_pkg::*;

  typedef enum logic [9:0] {
    S_CLEAR = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_MOD   = 10'b0000000100,
    S_HEAD  = 10'b0000001000,
    S_HEADW = 10'b0000010000,
    S_ENT   = 10'b0000100000,
    S_CHECK = 10'b0001000000,
    S_ACT   = 10'b0010000000,
    S_LINK  = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  // memories
  logic [LNK_W-1:0] head_mem [NUM_BUCKETS];
  logic [KEY_W-1:0] key_mem  [NUM_ENTRIES];
  logic [VAL_W-1:0] val_mem  [NUM_ENTRIES];
  logic [LNK_W-1:0] next_mem [NUM_ENTRIES];
  logic [IDX_W-1:0] free_mem [NUM_ENTRIES];

  logic [BC_W-1:0]  bc_r;
  logic [CNT_W-1:0] total_r;
  logic [BKT_W:0]   clr_r;
  logic [1:0]       cmd_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [BKT_W-1:0] bkt_r;
  logic [LNK_W-1:0] cur_r, prev_r, hit_next_r;
  logic [IDX_W-1:0] alloc_r;
  logic [2:0]       status_r;
  logic [VAL_W-1:0] found_r;
  logic             out_valid_r;
  logic             linked_prev_r;

  // registered read data
  logic [LNK_W-1:0] head_rd;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;
  logic [LNK_W-1:0] next_rd;
  logic [IDX_W-1:0] free_rd;

  mod_req_t mreq;
  mod_rsp_t mrsp;

  chm_mod u_mod (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

  logic accept_in;
  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign accept_in  = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, total_r, found_r, status_r};

  assign mreq.start = accept_in;
  assign mreq.key   = in_tdata[32:2];
  assign mreq.bc    = bc_r;

  logic cur_nil;
  assign cur_nil = cur_r[IDX_W];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == (BKT_W+1)'(NUM_BUCKETS - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (accept_in) state_nxt = S_MOD;
      S_MOD:   if (mrsp.done) state_nxt = S_HEAD;
      S_HEAD:  state_nxt = S_HEADW;
      S_HEADW: state_nxt = S_ENT;
      S_ENT:   state_nxt = S_CHECK;
      S_CHECK: begin
        if (cur_nil || key_rd == key_r) state_nxt = S_ACT;
        else state_nxt = S_ENT;
      end
      S_ACT:   state_nxt = S_LINK;
      S_LINK:  state_nxt = S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // status decided at the end of the walk
  status_t act_status;
  always_comb begin
    act_status = ST_OK;
    if (cmd_r == CMD_INSERT) begin
      if (key_r == '0) act_status = ST_INVALID;
      else if (!cur_nil) act_status = ST_DUPLICATE;
      else if (total_r >= CNT_W'(NUM_ENTRIES)) act_status = ST_FULL;
    end else if (cur_nil) begin
      act_status = ST_NOT_FOUND;
    end
  end

  logic act_ins, act_upd;
  assign act_ins = (state_r == S_ACT) && (cmd_r == CMD_INSERT) && (act_status == ST_OK);
  assign act_upd = (state_r == S_ACT) && (cmd_r == CMD_UPDATE) && (act_status == ST_OK);

  // head memory: clearing pass, read in S_HEAD, write in S_LINK
  logic             head_we;
  logic [BKT_W-1:0] head_wa;
  logic [LNK_W-1:0] head_wd;
  logic             ins_ok, del_ok;
  assign ins_ok = (cmd_r == CMD_INSERT) && (status_r == ST_OK);
  assign del_ok = (cmd_r == CMD_DELETE) && (status_r == ST_OK);

  always_comb begin
    head_we = 1'b0;
    head_wa = bkt_r;
    head_wd = NIL_LINK;
    if (state_r == S_CLEAR) begin
      head_we = 1'b1;
      head_wa = clr_r[BKT_W-1:0];
    end else if (state_r == S_LINK && !linked_prev_r) begin
      if (ins_ok) begin
        head_we = 1'b1;
        head_wd = {1'b0, alloc_r};
      end else if (del_ok) begin
        head_we = 1'b1;
        head_wd = hit_next_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    head_rd <= head_mem[bkt_r];
  end

  // entry memories read at cur
  logic [IDX_W-1:0] cur_idx;
  assign cur_idx = cur_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    key_rd  <= key_mem[cur_idx];
    val_rd  <= val_mem[cur_idx];
    next_rd <= next_mem[cur_idx];
    free_rd <= free_mem[total_r[IDX_W-1:0]];
  end

  // free stack: slot i initially i, emulated by a fill mark
  logic [CNT_W-1:0] fill_r;
  logic [IDX_W-1:0] free_val;
  assign free_val = (total_r < fill_r) ? free_rd : total_r[IDX_W-1:0];

  // entry writes
  always_ff @(posedge clk) begin
    if (act_ins) begin
      key_mem[free_val]  <= key_r;
      val_mem[free_val]  <= val_r;
      next_mem[free_val] <= NIL_LINK;
    end else if (act_upd) begin
      val_mem[cur_idx] <= val_r;
    end else if (state_r == S_LINK && linked_prev_r && (ins_ok || del_ok)) begin
      next_mem[prev_r[IDX_W-1:0]] <= ins_ok ? {1'b0, alloc_r} : hit_next_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LINK && del_ok)
      free_mem[total_r[IDX_W-1:0] - IDX_W'(1)] <= cur_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      bc_r        <= BC_W'(64);
      total_r     <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (cfg_valid && cfg_ready) bc_r <= cfg_data[BC_W-1:0];
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      if (state_r == S_OUT) out_valid_r <= 1'b1;
      if (state_r == S_LINK && ins_ok) total_r <= total_r + 1'b1;
      if (state_r == S_LINK && del_ok) begin
        total_r <= total_r - 1'b1;
        if (fill_r < total_r) fill_r <= total_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (accept_in) begin
        cmd_r <= in_tdata[1:0];
        key_r <= in_tdata[32:2];
        val_r <= in_tdata[64:33];
      end
      S_MOD: bkt_r <= mrsp.bucket;
      S_HEAD: prev_r <= NIL_LINK;
      S_HEADW: cur_r <= head_rd;
      S_CHECK: if (!(cur_nil || key_rd == key_r)) begin
        prev_r <= cur_r;
        cur_r  <= next_rd;
      end
      S_ACT: begin
        hit_next_r    <= next_rd;
        linked_prev_r <= !prev_r[IDX_W];
        alloc_r       <= free_val;
        status_r      <= act_status;
        found_r       <= (!cur_nil && cmd_r == CMD_SEARCH) ? val_rd : '0;
      end
      default: ;
    endcase
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r));
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata));
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid);
  a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(NUM_ENTRIES));
endmodule

// ----- tb/tb.sv -----
// testbench for the chained hash map engine: directed and random requests against a scoreboard
`timescale 1ns / 1ps
module tb;
  import chm_pkg::*;

  class hash_map_scoreboard;
    int unsigned   bucket_sel;
    int unsigned   heads[NUM_BUCKETS];
    bit [30:0]     keys[NUM_ENTRIES];
    bit [31:0]     vals[NUM_ENTRIES];
    int unsigned   links[NUM_ENTRIES];
    int unsigned   free_stack[NUM_ENTRIES];
    int unsigned   live;
    bit [47:0]     pending[$];
    int            errors;
    int            checked;

    function void clear();
      bucket_sel = 64;
      foreach (heads[i]) heads[i] = NUM_ENTRIES;
      foreach (free_stack[i]) begin
        free_stack[i] = i;
        links[i] = NUM_ENTRIES;
      end
      live = 0;
    endfunction

    // predict the response for one accepted request and queue it
    function void note_request(cmd_t cmd, bit [30:0] key, bit [31:0] val);
      int unsigned nb, bkt, cur, prev, steps, e;
      status_t st;
      bit [31:0] found;
      nb = bucket_sel == 0 ? 1 : (bucket_sel > NUM_BUCKETS ? NUM_BUCKETS : bucket_sel);
      bkt = key % nb;
      cur = heads[bkt];
      prev = NUM_ENTRIES;
      steps = 0;
      st = ST_OK;
      found = 0;
      while (cur < NUM_ENTRIES && steps < NUM_ENTRIES && keys[cur] != key) begin
        prev = cur;
        cur = links[cur];
        steps++;
      end
      if (steps >= NUM_ENTRIES) cur = NUM_ENTRIES;
      if (cmd == CMD_INSERT) begin
        if (key == 0) st = ST_INVALID;
        else if (cur != NUM_ENTRIES) st = ST_DUPLICATE;
        else if (live >= NUM_ENTRIES) st = ST_FULL;
        else begin
          e = free_stack[live];
          live++;
          keys[e] = key;
          vals[e] = val;
          links[e] = NUM_ENTRIES;
          if (prev == NUM_ENTRIES) heads[bkt] = e;
          else links[prev] = e;
        end
      end else if (cur == NUM_ENTRIES) begin
        st = ST_NOT_FOUND;
      end else if (cmd == CMD_DELETE) begin
        if (prev == NUM_ENTRIES) heads[bkt] = links[cur];
        else links[prev] = links[cur];
        if (live > 0) begin
          live--;
          free_stack[live] = cur;
        end
      end else if (cmd == CMD_UPDATE) begin
        vals[cur] = val;
      end else begin
        found = vals[cur];
      end
      pending.push_back({4'b0, 9'(live), found, st});
    endfunction

    function void check_response(bit [47:0] got);
      bit [47:0] exp;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %h", $realtime, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got[2:0] != exp[2:0]) begin
        $display("%0t: status exp %0d got %0d", $realtime, exp[2:0], got[2:0]);
        errors++;
      end
      if (got[34:3] != exp[34:3]) begin
        $display("%0t: found_value exp %h got %h", $realtime, exp[34:3], got[34:3]);
        errors++;
      end
      if (got[43:35] != exp[43:35]) begin
        $display("%0t: entry_count exp %0d got %0d", $realtime, exp[43:35], got[43:35]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [47:0] out_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  hash_map_scoreboard sb = new();
  longint unsigned cycles = 0;
  bit          stim_done = 0;
  bit [30:0]   live_keys[$];
  int unsigned sent = 0;

  always #5 clk = ~clk;

  chained_hash_map_engine dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3_000_000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // response side: random stalls, sometimes none
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_response(out_tdata);
      if (out_tready && !(out_tvalid)) ;
      else if (!out_tready || out_tvalid) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
          out_tready <= 0;
          repeat (gap) begin
            @(posedge clk);
          end
        end
        out_tready <= 1;
      end
    end
  end

  // valid stays high into the next request when it follows with no gap
  task automatic send_request(cmd_t cmd, bit [30:0] key, bit [31:0] val, bit calm = 0);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {7'b0, val, key, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_request(cmd, key, val);
    sent++;
    if (cmd == CMD_INSERT && key != 0) live_keys.push_back(key);
  endtask

  task automatic wait_drained();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_buckets(bit [7:0] n);
    cfg_valid <= 1;
    cfg_data <= n;
    do @(posedge clk); while (!cfg_ready);
    sb.bucket_sel = n[6:0];
    cfg_valid <= 0;
  endtask

  // empty the table so the bucket count can change
  task automatic drain_table();
    bit [30:0] k;
    while (live_keys.size() != 0) begin
      k = live_keys.pop_front();
      send_request(CMD_DELETE, k, $urandom, $urandom_range(0, 1) == 1);
    end
    wait_drained();
  endtask

  function automatic bit [30:0] pick_key(int unsigned span);
    if (live_keys.size() != 0 && $urandom_range(0, 2) != 0)
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return (span == 0) ? 31'($urandom) : 31'($urandom_range(0, span));
  endfunction

  task automatic random_phase(int unsigned count, int unsigned span);
    cmd_t cmd;
    bit [30:0] k;
    repeat (count) begin
      cmd = cmd_t'($urandom_range(0, 3));
      k = pick_key(span);
      send_request(cmd, k, {$urandom}, $urandom_range(0, 4) == 0);
      if (cmd == CMD_DELETE)
        foreach (live_keys[i]) if (live_keys[i] == k) begin
          live_keys.delete(i);
          break;
        end
      if (cmd == CMD_INSERT && live_keys.size() > 1) begin
        // drop the duplicate entry pushed for a key already present
        for (int i = 0; i < live_keys.size() - 1; i++)
          if (live_keys[i] == k) begin
            void'(live_keys.pop_back());
            break;
          end
      end
    end
  endtask

  initial begin
    sb.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // directed: field extremes, every command, special cases
    send_request(CMD_INSERT, 0, 32'hFFFF_FFFF);
    send_request(CMD_DELETE, 0, 0);
    send_request(CMD_SEARCH, 0, 0);
    send_request(CMD_UPDATE, 31'h7FFF_FFFF, 0);
    send_request(CMD_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_request(CMD_INSERT, 31'h7FFF_FFFF, 32'h1234_5678);
    send_request(CMD_SEARCH, 31'h7FFF_FFFF, 0);
    send_request(CMD_INSERT, 1, 0);
    send_request(CMD_INSERT, 65, 32'hA5A5_5A5A);
    send_request(CMD_INSERT, 129, 32'h5A5A_A5A5);
    send_request(CMD_UPDATE, 65, 32'hDEAD_BEEF);
    send_request(CMD_SEARCH, 65, 32'hFFFF_FFFF);
    send_request(CMD_DELETE, 65, 0);
    send_request(CMD_SEARCH, 129, 0);
    send_request(CMD_SEARCH, 65, 0);
    send_request(CMD_DELETE, 1, 0);
    send_request(CMD_SEARCH, 129, 0);
    drain_table();

    // fill the pool to full, then probe and empty it, with one bucket
    write_buckets(8'd1);
    for (int i = 1; i <= NUM_ENTRIES + 2; i++) send_request(CMD_INSERT, 31'(i * 3), {$urandom}, 1);
    send_request(CMD_INSERT, 3, 0, 1);
    send_request(CMD_SEARCH, 31'(NUM_ENTRIES * 3), 0, 1);
    live_keys.delete();
    for (int i = 1; i <= NUM_ENTRIES; i++) live_keys.push_back(31'(i * 3));
    drain_table();

    write_buckets(8'd0);
    random_phase(50, 40);
    drain_table();

    write_buckets(8'd64);
    random_phase(90, 300);
    drain_table();

    write_buckets(8'd127);
    random_phase(50, 0);
    drain_table();

    write_buckets(8'd7);
    random_phase(70, 60);

    // no rehash: shrink bucket count with entries still present
    wait_drained();
    write_buckets(8'd3);
    random_phase(30, 60);
    wait_drained();

    $display("ran %0d requests over bucket counts 1, 0, 64, 127, 7 and 3", sent);
    $display("checked %0d responses, including a full pool and no-rehash probes",
             sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
